[hw/rtl/ptsd_pkg.sv]
package ptsd_pkg;

	// Coordinate and distance widths fixed by the request and result formats.
	localparam int COORD_W = 16;
	localparam int DIST_W  = 34;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		coord_t vert0_x;
		coord_t vert0_y;
		coord_t vert0_z;
		coord_t vert1_x;
		coord_t vert1_y;
		coord_t vert1_z;
		coord_t vert2_x;
		coord_t vert2_y;
		coord_t vert2_z;
	} req_t;

	typedef struct packed {
		logic [DIST_W-1:0] sqr_distance;
		coord_t            closest_x;
		coord_t            closest_y;
		coord_t            closest_z;
		logic              degenerate;
	} res_t;

	// How s, t and the distance are formed once the region is known.
	typedef enum logic [2:0] {
		K_CONST,
		K_E0,
		K_E1,
		K_INT,
		K_SC,
		K_TC
	} kind_t;

	// Quotient cases settled before the divider iterations.
	typedef enum logic [1:0] {
		SP_NONE,
		SP_ZERO,
		SP_ONE
	} spec_t;

endpackage

[hw/rtl/point_triangle_sqr_distance_top.sv]
// Throughput: one request per cycle; the whole pipeline advances together and
// holds in place while a finished result is not taken.
// The two quotient dividers resolve one bit per stage, which sets the depth.
// Reset clears every stage valid bit at once; data registers are not reset.
module point_triangle_sqr_distance_top
	import ptsd_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int F   = FRAC_BITS;
	localparam int SW  = F + 1;
	localparam int EDW = COORD_W + 1;
	localparam int AW  = 2 * EDW + 4;
	localparam int PW  = 2 * AW;
	localparam int DTW = PW + 1;
	localparam int RW  = DTW + 1;
	localparam int XW  = AW + 2;
	localparam int IW  = AW + SW + 3;
	localparam int EW  = IW + SW + 3;
	localparam int CLW = COORD_W + SW + 3;

	localparam logic [SW-1:0]     ONE_FX   = {1'b1, {F{1'b0}}};
	localparam logic [DIST_W-1:0] DIST_SAT = '1;

	typedef logic signed [EDW-1:0] dif_t;
	typedef logic signed [AW-1:0]  dot_t;

	typedef struct packed {
		dif_t [2:0] v0;
		dif_t [2:0] e0;
		dif_t [2:0] e1;
	} geo_t;

	typedef struct packed {
		dot_t a00;
		dot_t a01;
		dot_t a11;
		dot_t b0;
		dot_t b1;
		dot_t c;
	} quad_t;

	typedef struct packed {
		kind_t                kind;
		logic [SW-1:0]        sc;
		logic [SW-1:0]        tc;
		logic signed [XW-1:0] x;
		dot_t                 eb;
		logic                 deg;
		quad_t                q;
		geo_t                 g;
	} mid_t;

	// Global advance: every stage moves when the output register can take data.
	logic en;
	logic res_valid_q;
	res_t res_q;

	assign en        = !res_valid_q || res_ready;
	assign req_ready = en;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Valid bits of all stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [F:0] vld_sd;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_sd      <= '0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			vld_s8      <= 1'b0;
			vld_s9      <= 1'b0;
			vld_s10     <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= req_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_sd      <= {vld_sd[F-1:0], vld_s5};
			vld_s6      <= vld_sd[F];
			vld_s7      <= vld_s6;
			vld_s8      <= vld_s7;
			vld_s9      <= vld_s8;
			vld_s10     <= vld_s9;
			res_valid_q <= vld_s10;
		end
	end

	// Stage 1: edge vectors and offset from the query point.
	coord_t pnt [3];
	coord_t va  [3];
	coord_t vb  [3];
	coord_t vc  [3];

	always_comb begin
		pnt[0] = req.point_x;
		pnt[1] = req.point_y;
		pnt[2] = req.point_z;
		va[0]  = req.vert0_x;
		va[1]  = req.vert0_y;
		va[2]  = req.vert0_z;
		vb[0]  = req.vert1_x;
		vb[1]  = req.vert1_y;
		vb[2]  = req.vert1_z;
		vc[0]  = req.vert2_x;
		vc[1]  = req.vert2_y;
		vc[2]  = req.vert2_z;
	end

	geo_t       g_s1;
	dif_t [2:0] d_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				g_s1.v0[i] <= EDW'(va[i]);
				g_s1.e0[i] <= EDW'(vb[i]) - EDW'(va[i]);
				g_s1.e1[i] <= EDW'(vc[i]) - EDW'(va[i]);
				d_s1[i]    <= EDW'(va[i]) - EDW'(pnt[i]);
			end
		end
	end

	// Stage 2: the six dot products.
	quad_t q_s2;
	geo_t  g_s2;
	quad_t dots;

	always_comb begin
		dots = '0;
		for (int i = 0; i < 3; i++) begin
			dots.a00 = dots.a00 + AW'(g_s1.e0[i]) * AW'(g_s1.e0[i]);
			dots.a01 = dots.a01 + AW'(g_s1.e0[i]) * AW'(g_s1.e1[i]);
			dots.a11 = dots.a11 + AW'(g_s1.e1[i]) * AW'(g_s1.e1[i]);
			dots.b0  = dots.b0 + AW'(d_s1[i]) * AW'(g_s1.e0[i]);
			dots.b1  = dots.b1 + AW'(d_s1[i]) * AW'(g_s1.e1[i]);
			dots.c   = dots.c + AW'(d_s1[i]) * AW'(d_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2 <= dots;
			g_s2 <= g_s1;
		end
	end

	// Stage 3: second-order products for det, S and T.
	logic signed [PW-1:0] paa_s3, pww_s3, pwb1_s3, pab0_s3, pwb0_s3, pab1_s3;
	quad_t q_s3;
	geo_t  g_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			paa_s3  <= PW'(q_s2.a00) * PW'(q_s2.a11);
			pww_s3  <= PW'(q_s2.a01) * PW'(q_s2.a01);
			pwb1_s3 <= PW'(q_s2.a01) * PW'(q_s2.b1);
			pab0_s3 <= PW'(q_s2.a11) * PW'(q_s2.b0);
			pwb0_s3 <= PW'(q_s2.a01) * PW'(q_s2.b0);
			pab1_s3 <= PW'(q_s2.a00) * PW'(q_s2.b1);
			q_s3    <= q_s2;
			g_s3    <= g_s2;
		end
	end

	// Stage 4: det magnitude, S, T and the edge divisor.
	logic signed [DTW-1:0] det_s4, s_num_s4, t_num_s4;
	logic signed [XW-1:0]  den_s4;
	quad_t q_s4;
	geo_t  g_s4;
	logic signed [DTW-1:0] det_raw;

	assign det_raw = DTW'(paa_s3) - DTW'(pww_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4   <= det_raw[DTW-1] ? -det_raw : det_raw;
			s_num_s4 <= DTW'(pwb1_s3) - DTW'(pab0_s3);
			t_num_s4 <= DTW'(pwb0_s3) - DTW'(pab1_s3);
			den_s4   <= XW'(q_s3.a00) - (XW'(q_s3.a01) <<< 1) + XW'(q_s3.a11);
			q_s4     <= q_s3;
			g_s4     <= g_s3;
		end
	end

	// Stage 5: region split; picks the quotients to form and the formula.
	mid_t                 mid;
	logic signed [RW-1:0] n0, d0, n1, d1;
	mid_t                 mid_s5;
	logic signed [RW-1:0] n0_s5, d0_s5, n1_s5, d1_s5;

	always_comb begin
		logic signed [RW-1:0] st_sum;
		logic signed [XW-1:0] xa0, xa1, ra, rb, diff, num, nb0, nb1;
		logic                 use_a0, use_a1;
		st_sum = RW'(s_num_s4) + RW'(t_num_s4);
		xa0    = XW'(q_s4.a00) + (XW'(q_s4.b0) <<< 1) + XW'(q_s4.c);
		xa1    = XW'(q_s4.a11) + (XW'(q_s4.b1) <<< 1) + XW'(q_s4.c);
		nb0    = -XW'(q_s4.b0);
		nb1    = -XW'(q_s4.b1);
		ra     = '0;
		rb     = '0;
		diff   = '0;
		num    = '0;
		use_a0 = 1'b0;
		use_a1 = 1'b0;
		mid      = '0;
		mid.kind = K_CONST;
		mid.x    = XW'(q_s4.c);
		mid.eb   = q_s4.b0;
		mid.q    = q_s4;
		mid.g    = g_s4;
		n0 = '0;
		d0 = '0;
		n1 = '0;
		d1 = '0;
		if (st_sum <= RW'(det_s4)) begin
			if (s_num_s4 < 0) begin
				if (t_num_s4 < 0 && q_s4.b0 < 0) begin
					use_a0 = 1'b1;
				end else begin
					use_a1 = 1'b1;
				end
			end else if (t_num_s4 < 0) begin
				use_a0 = 1'b1;
			end else begin
				mid.kind = K_INT;
				mid.deg  = (det_s4 == '0);
				n0 = RW'(s_num_s4);
				d0 = RW'(det_s4);
				n1 = RW'(t_num_s4);
				d1 = RW'(det_s4);
			end
		end else if (s_num_s4 < 0) begin
			ra   = XW'(q_s4.a01) + XW'(q_s4.b0);
			rb   = XW'(q_s4.a11) + XW'(q_s4.b1);
			diff = rb - ra;
			if (rb > ra) begin
				if (diff >= den_s4) begin
					mid.sc = ONE_FX;
					mid.x  = xa0;
				end else begin
					mid.kind = K_SC;
					n0 = RW'(diff);
					d0 = RW'(den_s4);
				end
			end else begin
				use_a1 = 1'b1;
			end
		end else if (t_num_s4 < 0) begin
			ra   = XW'(q_s4.a01) + XW'(q_s4.b1);
			rb   = XW'(q_s4.a00) + XW'(q_s4.b0);
			diff = rb - ra;
			if (rb > ra) begin
				if (diff >= den_s4) begin
					mid.tc = ONE_FX;
					mid.x  = xa1;
				end else begin
					mid.kind = K_TC;
					n0 = RW'(diff);
					d0 = RW'(den_s4);
				end
			end else begin
				use_a0 = 1'b1;
			end
		end else begin
			num = XW'(q_s4.a11) + XW'(q_s4.b1) - XW'(q_s4.a01) - XW'(q_s4.b0);
			if (num <= 0) begin
				mid.tc = ONE_FX;
				mid.x  = xa1;
			end else if (num >= den_s4) begin
				mid.sc = ONE_FX;
				mid.x  = xa0;
			end else begin
				mid.kind = K_SC;
				n0 = RW'(num);
				d0 = RW'(den_s4);
			end
		end
		// Closest point on the first edge (t = 0).
		if (use_a0) begin
			if (q_s4.b0 >= 0) begin
				mid.x = XW'(q_s4.c);
			end else if (nb0 >= XW'(q_s4.a00)) begin
				mid.sc = ONE_FX;
				mid.x  = xa0;
			end else begin
				mid.kind = K_E0;
				mid.eb   = q_s4.b0;
				n0 = RW'(nb0);
				d0 = RW'(q_s4.a00);
			end
		end
		// Closest point on the other edge, e1 (s = 0).
		if (use_a1) begin
			if (q_s4.b1 >= 0) begin
				mid.x = XW'(q_s4.c);
			end else if (nb1 >= XW'(q_s4.a11)) begin
				mid.tc = ONE_FX;
				mid.x  = xa1;
			end else begin
				mid.kind = K_E1;
				mid.eb   = q_s4.b1;
				n0 = RW'(nb1);
				d0 = RW'(q_s4.a11);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s5 <= mid;
			n0_s5  <= n0;
			d0_s5  <= d0;
			n1_s5  <= n1;
			d1_s5  <= d1;
		end
	end

	// Divider entry: settle the zero and one cases, load the remainders.
	logic [RW-1:0] r0_sd [0:F];
	logic [RW-1:0] r1_sd [0:F];
	logic [RW-1:0] dd0_sd [0:F];
	logic [RW-1:0] dd1_sd [0:F];
	logic [F-1:0]  q0_sd [0:F];
	logic [F-1:0]  q1_sd [0:F];
	spec_t         sp0_sd [0:F];
	spec_t         sp1_sd [0:F];
	mid_t          mid_sd [0:F];

	always_ff @(posedge clk) begin
		if (en) begin
			r0_sd[0]  <= n0_s5;
			r1_sd[0]  <= n1_s5;
			dd0_sd[0] <= d0_s5;
			dd1_sd[0] <= d1_s5;
			q0_sd[0]  <= '0;
			q1_sd[0]  <= '0;
			mid_sd[0] <= mid_s5;
			if (n0_s5 < 0 || d0_s5 <= 0) begin
				sp0_sd[0] <= SP_ZERO;
			end else if (n0_s5 >= d0_s5) begin
				sp0_sd[0] <= SP_ONE;
			end else begin
				sp0_sd[0] <= SP_NONE;
			end
			if (n1_s5 < 0 || d1_s5 <= 0) begin
				sp1_sd[0] <= SP_ZERO;
			end else if (n1_s5 >= d1_s5) begin
				sp1_sd[0] <= SP_ONE;
			end else begin
				sp1_sd[0] <= SP_NONE;
			end
		end
	end

	// Restoring division, one quotient bit per stage for both dividers.
	for (genvar k = 1; k <= F; k++) begin : g_div
		logic [RW:0] r2a, r2b;
		logic        gea, geb;

		always_comb begin
			r2a = {r0_sd[k-1], 1'b0};
			r2b = {r1_sd[k-1], 1'b0};
			gea = (r2a >= {1'b0, dd0_sd[k-1]});
			geb = (r2b >= {1'b0, dd1_sd[k-1]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r0_sd[k]  <= gea ? RW'(r2a - {1'b0, dd0_sd[k-1]}) : RW'(r2a);
				r1_sd[k]  <= geb ? RW'(r2b - {1'b0, dd1_sd[k-1]}) : RW'(r2b);
				q0_sd[k]  <= {q0_sd[k-1][F-2:0], gea};
				q1_sd[k]  <= {q1_sd[k-1][F-2:0], geb};
				dd0_sd[k] <= dd0_sd[k-1];
				dd1_sd[k] <= dd1_sd[k-1];
				sp0_sd[k] <= sp0_sd[k-1];
				sp1_sd[k] <= sp1_sd[k-1];
				mid_sd[k] <= mid_sd[k-1];
			end
		end
	end

	// Stage 6: final quotients and the s, t pair.
	logic [SW-1:0] qa, qb, s_val, t_val;
	logic [SW-1:0] s_s6, t_s6;
	mid_t          mid_s6;

	always_comb begin
		unique case (sp0_sd[F])
			SP_ONE:  qa = ONE_FX;
			SP_ZERO: qa = '0;
			default: qa = {1'b0, q0_sd[F]};
		endcase
		unique case (sp1_sd[F])
			SP_ONE:  qb = ONE_FX;
			SP_ZERO: qb = '0;
			default: qb = {1'b0, q1_sd[F]};
		endcase
		unique case (mid_sd[F].kind)
			K_E0: begin
				s_val = qa;
				t_val = '0;
			end
			K_E1: begin
				s_val = '0;
				t_val = qa;
			end
			K_INT: begin
				s_val = qa;
				t_val = qb;
			end
			K_SC: begin
				s_val = qa;
				t_val = ONE_FX - qa;
			end
			K_TC: begin
				s_val = ONE_FX - qa;
				t_val = qa;
			end
			default: begin
				s_val = mid_sd[F].sc;
				t_val = mid_sd[F].tc;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s6   <= s_val;
			t_s6   <= t_val;
			mid_s6 <= mid_sd[F];
		end
	end

	// Stage 7: products of s and t with the dot terms and edge vectors.
	logic signed [SW:0]    ss6, ts6, fs6;
	logic signed [IW-1:0]  a00s_s7, a01t_s7, a01s_s7, a11t_s7, ebf_s7;
	logic signed [CLW-1:0] se0_s7 [3];
	logic signed [CLW-1:0] te1_s7 [3];
	logic [SW-1:0]         s_s7, t_s7;
	mid_t                  mid_s7;

	assign ss6 = $signed({1'b0, s_s6});
	assign ts6 = $signed({1'b0, t_s6});
	assign fs6 = (mid_s6.kind == K_E0) ? ss6 : ts6;

	always_ff @(posedge clk) begin
		if (en) begin
			a00s_s7 <= IW'(mid_s6.q.a00) * IW'(ss6);
			a01t_s7 <= IW'(mid_s6.q.a01) * IW'(ts6);
			a01s_s7 <= IW'(mid_s6.q.a01) * IW'(ss6);
			a11t_s7 <= IW'(mid_s6.q.a11) * IW'(ts6);
			ebf_s7  <= IW'(mid_s6.eb) * IW'(fs6);
			for (int i = 0; i < 3; i++) begin
				se0_s7[i] <= CLW'(mid_s6.g.e0[i]) * CLW'(ss6);
				te1_s7[i] <= CLW'(mid_s6.g.e1[i]) * CLW'(ts6);
			end
			s_s7   <= s_s6;
			t_s7   <= t_s6;
			mid_s7 <= mid_s6;
		end
	end

	// Stage 8: inner sums, edge or vertex distance, closest point.
	logic signed [IW-1:0]  i0_s8, i1_s8;
	logic signed [EW-1:0]  ealt_s8;
	coord_t [2:0]          cl_s8;
	logic [SW-1:0]         s_s8, t_s8;
	kind_t                 kind_s8;
	logic                  deg_s8;
	dot_t                  c_s8;
	logic signed [CLW-1:0] acc [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = (CLW'(mid_s7.g.v0[i]) <<< F) + se0_s7[i] + te1_s7[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i0_s8 <= a00s_s7 + a01t_s7 + (IW'(mid_s7.q.b0) <<< (F + 1));
			i1_s8 <= a01s_s7 + a11t_s7 + (IW'(mid_s7.q.b1) <<< (F + 1));
			if (mid_s7.kind == K_CONST) begin
				ealt_s8 <= EW'(mid_s7.x) <<< (2 * F);
			end else begin
				ealt_s8 <= (EW'(ebf_s7) <<< F) + (EW'(mid_s7.q.c) <<< (2 * F));
			end
			for (int i = 0; i < 3; i++) begin
				cl_s8[i] <= COORD_W'(acc[i] >>> F);
			end
			s_s8    <= s_s7;
			t_s8    <= t_s7;
			kind_s8 <= mid_s7.kind;
			deg_s8  <= mid_s7.deg;
			c_s8    <= mid_s7.q.c;
		end
	end

	// Stage 9: outer products of the full quadratic form.
	logic signed [EW-1:0] si0_s9, ti1_s9, ealt_s9;
	coord_t [2:0]         cl_s9;
	kind_t                kind_s9;
	logic                 deg_s9;
	dot_t                 c_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			si0_s9  <= EW'($signed({1'b0, s_s8})) * EW'(i0_s8);
			ti1_s9  <= EW'($signed({1'b0, t_s8})) * EW'(i1_s8);
			ealt_s9 <= ealt_s8;
			cl_s9   <= cl_s8;
			kind_s9 <= kind_s8;
			deg_s9  <= deg_s8;
			c_s9    <= c_s8;
		end
	end

	// Stage 10: pick the region formula and take its magnitude.
	logic signed [EW-1:0] efull, esel;
	logic [EW-1:0]        eabs_s10;
	coord_t [2:0]         cl_s10;
	logic                 deg_s10;

	always_comb begin
		efull = si0_s9 + ti1_s9 + (EW'(c_s9) <<< (2 * F));
		if (kind_s9 == K_INT || kind_s9 == K_SC || kind_s9 == K_TC) begin
			esel = efull;
		end else begin
			esel = ealt_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eabs_s10 <= esel[EW-1] ? EW'(-esel) : EW'(esel);
			cl_s10   <= cl_s9;
			deg_s10  <= deg_s9;
		end
	end

	// Output register: drop the fraction and saturate the distance.
	logic sat;

	assign sat = |eabs_s10[EW-1:2*F+DIST_W];

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.sqr_distance <= sat ? DIST_SAT : eabs_s10[2*F+DIST_W-1:2*F];
			res_q.closest_x    <= cl_s10[0];
			res_q.closest_y    <= cl_s10[1];
			res_q.closest_z    <= cl_s10[2];
			res_q.degenerate   <= deg_s10;
		end
	end

	// The last divider remainder stays below its divisor when it divided.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sd[F] && sp0_sd[F] == SP_NONE) |-> (r0_sd[F] < dd0_sd[F]))
		else $error("divider remainder not below divisor");

	// A point on the first edge has t equal to zero.
	a_edge_t: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && mid_s6.kind == K_E0) |-> (t_s6 == '0))
		else $error("edge case with nonzero t");

	// A stall holds the first stage in place.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s1) && $stable(g_s1)))
		else $error("first stage changed during stall");

endmodule
